@@ design/rgbseq_pkg.sv @@
// Package for the RGB LED command sequencer: command kinds, modes, phases,
// configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package rgbseq_pkg;

    // Command characters
    localparam logic [7:0] CH_FLASH  = 8'h61;
    localparam logic [7:0] CH_FADE   = 8'h64;
    localparam logic [7:0] CH_RED_DN = 8'h72;
    localparam logic [7:0] CH_RED_UP = 8'h74;
    localparam logic [7:0] CH_GRN_DN = 8'h67;
    localparam logic [7:0] CH_GRN_UP = 8'h68;
    localparam logic [7:0] CH_BLU_DN = 8'h62;
    localparam logic [7:0] CH_BLU_UP = 8'h6E;

    localparam logic [7:0] LEVEL_FULL = 8'hFF;

    // Timing counter width default
    localparam int TICK_COUNT_WIDTH = 16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes and widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_CAP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_CAP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_HOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_STEP  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_PAUSE = 3'd4;

    localparam logic [7:0]  RST_RED_CAP    = 8'd81;
    localparam logic [7:0]  RST_GREEN_CAP  = 8'd100;
    localparam logic [15:0] RST_FLASH_HOLD = 16'd500;
    localparam logic [9:0]  RST_FADE_STEP  = 10'd10;
    localparam logic [15:0] RST_FADE_PAUSE = 16'd150;

    typedef struct packed {
        logic [7:0]  red_cap;
        logic [7:0]  green_cap;
        logic [15:0] flash_hold_ticks;
        logic [9:0]  fade_step_ticks;
        logic [15:0] fade_pause_ticks;
    } cfg_t;

    // Classified command, carried through the queue
    typedef enum logic [3:0] {
        CMD_TICK,
        CMD_RED_DN,
        CMD_RED_UP,
        CMD_GRN_DN,
        CMD_GRN_UP,
        CMD_BLU_DN,
        CMD_BLU_UP,
        CMD_FLASH,
        CMD_FADE,
        CMD_OTHER
    } cmd_kind_t;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_FLASH  = 2'd1,
        MODE_FADE   = 2'd2,
        MODE_EXIT   = 2'd3
    } mode_t;

    typedef logic [2:0] phase_t;

    // Flash phases
    localparam phase_t FLASH_RED   = 3'd0;
    localparam phase_t FLASH_GREEN = 3'd1;
    localparam phase_t FLASH_BLUE  = 3'd2;

    // Fade phases; FADE_CHECK is only an entry point, never stored
    localparam phase_t FADE_RED_UP   = 3'd0;
    localparam phase_t FADE_RG_CROSS = 3'd1;
    localparam phase_t FADE_GB_CROSS = 3'd2;
    localparam phase_t FADE_RED_BACK = 3'd3;
    localparam phase_t FADE_GRN_BACK = 3'd4;
    localparam phase_t FADE_GB_DOWN  = 3'd5;
    localparam phase_t FADE_PAUSE    = 3'd6;
    localparam phase_t FADE_CHECK    = 3'd7;

    localparam int OUT_DATA_W = 32;

endpackage

@@ design/rgbseq_front.sv @@
// Front end: takes input transactions and classifies them into command kinds.
// Depends on rgbseq_pkg.
`timescale 1ns / 1ps

module rgbseq_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] cmd_byte
    input  logic                  s_tuser,   // [0] op
    input  logic                  q_full,
    output logic                  q_push,
    output rgbseq_pkg::cmd_kind_t q_kind
);

    // Accept while the queue has room
    assign s_tready = ~q_full;
    assign q_push   = s_tvalid & ~q_full;

    // Decode the command character
    always_comb begin
        if (s_tuser) begin
            q_kind = rgbseq_pkg::CMD_TICK;
        end else begin
            unique case (s_tdata)
                rgbseq_pkg::CH_RED_DN: q_kind = rgbseq_pkg::CMD_RED_DN;
                rgbseq_pkg::CH_RED_UP: q_kind = rgbseq_pkg::CMD_RED_UP;
                rgbseq_pkg::CH_GRN_DN: q_kind = rgbseq_pkg::CMD_GRN_DN;
                rgbseq_pkg::CH_GRN_UP: q_kind = rgbseq_pkg::CMD_GRN_UP;
                rgbseq_pkg::CH_BLU_DN: q_kind = rgbseq_pkg::CMD_BLU_DN;
                rgbseq_pkg::CH_BLU_UP: q_kind = rgbseq_pkg::CMD_BLU_UP;
                rgbseq_pkg::CH_FLASH:  q_kind = rgbseq_pkg::CMD_FLASH;
                rgbseq_pkg::CH_FADE:   q_kind = rgbseq_pkg::CMD_FADE;
                default:               q_kind = rgbseq_pkg::CMD_OTHER;
            endcase
        end
    end

    // Never push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("front pushed into a full queue");

endmodule

@@ design/rgbseq_queue.sv @@
// Short queue of classified commands between front and back ends.
// Depends on rgbseq_pkg.
`timescale 1ns / 1ps

module rgbseq_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  rgbseq_pkg::cmd_kind_t push_kind,
    input  logic                  pop,
    output rgbseq_pkg::cmd_kind_t head_kind,
    output logic                  empty,
    output logic                  full
);

    localparam int DEPTH = rgbseq_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rgbseq_pkg::cmd_kind_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_kind = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_kind;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("pop from an empty queue");

endmodule

@@ design/rgbseq_back.sv @@
// Back end: configuration registers, LED levels, mode sequencer and the
// output register. Depends on rgbseq_pkg.
`timescale 1ns / 1ps

module rgbseq_back #(
    parameter int TICK_W = rgbseq_pkg::TICK_COUNT_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rgbseq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rgbseq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                q_empty,
    input  rgbseq_pkg::cmd_kind_t               q_kind,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rgbseq_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int CMP_W = (TICK_W > 16) ? TICK_W : 16;

    rgbseq_pkg::cfg_t  cfg_reg;
    rgbseq_pkg::mode_t mode_reg, mode_next;
    rgbseq_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        red_reg, red_next;
    logic [7:0]        green_reg, green_next;
    logic [7:0]        blue_reg, blue_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              exit_reg, exit_next;
    logic              m_tvalid_reg;
    logic [rgbseq_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red_cap          <= rgbseq_pkg::RST_RED_CAP;
            cfg_reg.green_cap        <= rgbseq_pkg::RST_GREEN_CAP;
            cfg_reg.flash_hold_ticks <= rgbseq_pkg::RST_FLASH_HOLD;
            cfg_reg.fade_step_ticks  <= rgbseq_pkg::RST_FADE_STEP;
            cfg_reg.fade_pause_ticks <= rgbseq_pkg::RST_FADE_PAUSE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rgbseq_pkg::CFG_RED_CAP:    cfg_reg.red_cap          <= cfg_wdata[7:0];
                rgbseq_pkg::CFG_GREEN_CAP:  cfg_reg.green_cap        <= cfg_wdata[7:0];
                rgbseq_pkg::CFG_FLASH_HOLD: cfg_reg.flash_hold_ticks <= cfg_wdata;
                rgbseq_pkg::CFG_FADE_STEP:  cfg_reg.fade_step_ticks  <= cfg_wdata[9:0];
                rgbseq_pkg::CFG_FADE_PAUSE: cfg_reg.fade_pause_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Take the next command when the output register is free or drains
    assign q_pop = ~q_empty & (~m_tvalid_reg | m_tready);

    // Wait expiry
    logic [15:0]       wait_sel, wait_eff;
    logic [TICK_W-1:0] tick_inc;
    logic              expire;

    always_comb begin
        if (mode_reg == rgbseq_pkg::MODE_FLASH) begin
            wait_sel = cfg_reg.flash_hold_ticks;
        end else if (mode_reg == rgbseq_pkg::MODE_FADE && phase_reg == rgbseq_pkg::FADE_PAUSE) begin
            wait_sel = cfg_reg.fade_pause_ticks;
        end else begin
            wait_sel = {6'd0, cfg_reg.fade_step_ticks};
        end
        wait_eff = (wait_sel == 16'd0) ? 16'd1 : wait_sel;
        tick_inc = tick_reg + 1'b1;
        expire   = (CMP_W'(tick_inc) >= CMP_W'(wait_eff)) || (&tick_inc);
    end

    // Fade step search: first phase from the entry point that has work
    rgbseq_pkg::phase_t fade_from, fade_eff, fr_phase;
    logic       fade_exit_flag, fr_exit;
    logic [7:0] fr_red, fr_green, fr_blue;
    logic       red_lt_cap, green_lt_cap, blue_lt_full, gb_nonzero;
    logic       from_check;

    always_comb begin
        if (mode_reg == rgbseq_pkg::MODE_FADE) begin
            fade_from      = (phase_reg == rgbseq_pkg::FADE_PAUSE) ?
                             rgbseq_pkg::FADE_CHECK : phase_reg;
            fade_exit_flag = exit_reg;
        end else begin
            fade_from      = rgbseq_pkg::FADE_RED_UP;
            fade_exit_flag = 1'b0;
        end
        red_lt_cap   = red_reg < cfg_reg.red_cap;
        green_lt_cap = green_reg < cfg_reg.green_cap;
        blue_lt_full = blue_reg != rgbseq_pkg::LEVEL_FULL;
        gb_nonzero   = (green_reg != 8'd0) || (blue_reg != 8'd0);
        from_check   = (fade_from == rgbseq_pkg::FADE_RED_UP) ||
                       (fade_from == rgbseq_pkg::FADE_CHECK);
        fade_eff     = from_check ? rgbseq_pkg::FADE_RG_CROSS : fade_from;

        fr_red   = red_reg;
        fr_green = green_reg;
        fr_blue  = blue_reg;
        fr_exit  = 1'b0;
        fr_phase = rgbseq_pkg::FADE_PAUSE;
        if (fade_from == rgbseq_pkg::FADE_RED_UP && red_lt_cap) begin
            fr_red   = red_reg + 1'b1;
            fr_phase = rgbseq_pkg::FADE_RED_UP;
        end else if (from_check && fade_exit_flag) begin
            fr_exit = 1'b1;
        end else if (fade_eff <= rgbseq_pkg::FADE_RG_CROSS && green_lt_cap) begin
            fr_red   = (red_reg != 8'd0) ? red_reg - 1'b1 : red_reg;
            fr_green = green_reg + 1'b1;
            fr_phase = rgbseq_pkg::FADE_RG_CROSS;
        end else if (fade_eff <= rgbseq_pkg::FADE_GB_CROSS && blue_lt_full) begin
            fr_green = (green_reg != 8'd0) ? green_reg - 1'b1 : green_reg;
            fr_blue  = blue_reg + 1'b1;
            fr_phase = rgbseq_pkg::FADE_GB_CROSS;
        end else if (fade_eff <= rgbseq_pkg::FADE_RED_BACK && red_lt_cap) begin
            fr_red   = red_reg + 1'b1;
            fr_phase = rgbseq_pkg::FADE_RED_BACK;
        end else if (fade_eff <= rgbseq_pkg::FADE_GRN_BACK && green_lt_cap) begin
            fr_green = green_reg + 1'b1;
            fr_phase = rgbseq_pkg::FADE_GRN_BACK;
        end else if (gb_nonzero) begin
            fr_green = (green_reg != 8'd0) ? green_reg - 1'b1 : green_reg;
            fr_blue  = (blue_reg != 8'd0) ? blue_reg - 1'b1 : blue_reg;
            fr_phase = rgbseq_pkg::FADE_GB_DOWN;
        end
    end

    // Mode sequencer: next state for the popped command
    always_comb begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        tick_next  = tick_reg;
        exit_next  = exit_reg;
        if (q_pop) begin
            unique case (mode_reg)
                rgbseq_pkg::MODE_MANUAL: begin
                    case (q_kind)
                        rgbseq_pkg::CMD_RED_DN:
                            if (red_reg != 8'd0) red_next = red_reg - 1'b1;
                        rgbseq_pkg::CMD_RED_UP:
                            if (red_reg != rgbseq_pkg::LEVEL_FULL) red_next = red_reg + 1'b1;
                        rgbseq_pkg::CMD_GRN_DN:
                            if (green_reg != 8'd0) green_next = green_reg - 1'b1;
                        rgbseq_pkg::CMD_GRN_UP:
                            if (green_reg != rgbseq_pkg::LEVEL_FULL) green_next = green_reg + 1'b1;
                        rgbseq_pkg::CMD_BLU_DN:
                            if (blue_reg != 8'd0) blue_next = blue_reg - 1'b1;
                        rgbseq_pkg::CMD_BLU_UP:
                            if (blue_reg != rgbseq_pkg::LEVEL_FULL) blue_next = blue_reg + 1'b1;
                        rgbseq_pkg::CMD_FLASH: begin
                            mode_next  = rgbseq_pkg::MODE_FLASH;
                            phase_next = rgbseq_pkg::FLASH_RED;
                            exit_next  = 1'b0;
                            tick_next  = '0;
                            red_next   = cfg_reg.red_cap;
                        end
                        rgbseq_pkg::CMD_FADE: begin
                            // entry from manual never takes the exit path
                            mode_next  = rgbseq_pkg::MODE_FADE;
                            exit_next  = 1'b0;
                            tick_next  = '0;
                            red_next   = fr_red;
                            green_next = fr_green;
                            blue_next  = fr_blue;
                            phase_next = fr_phase;
                        end
                        default: ;
                    endcase
                end
                rgbseq_pkg::MODE_FLASH: begin
                    if (q_kind != rgbseq_pkg::CMD_TICK) begin
                        exit_next = (q_kind != rgbseq_pkg::CMD_FLASH);
                    end else if (!expire) begin
                        tick_next = tick_inc;
                    end else begin
                        tick_next = '0;
                        if (phase_reg == rgbseq_pkg::FLASH_RED) begin
                            red_next   = 8'd0;
                            green_next = cfg_reg.green_cap;
                            phase_next = rgbseq_pkg::FLASH_GREEN;
                        end else if (phase_reg == rgbseq_pkg::FLASH_GREEN) begin
                            green_next = 8'd0;
                            blue_next  = rgbseq_pkg::LEVEL_FULL;
                            phase_next = rgbseq_pkg::FLASH_BLUE;
                        end else begin
                            blue_next = 8'd0;
                            if (exit_reg) begin
                                red_next   = 8'd0;
                                green_next = 8'd0;
                                mode_next  = rgbseq_pkg::MODE_MANUAL;
                                phase_next = '0;
                                exit_next  = 1'b0;
                            end else begin
                                red_next   = cfg_reg.red_cap;
                                phase_next = rgbseq_pkg::FLASH_RED;
                            end
                        end
                    end
                end
                rgbseq_pkg::MODE_FADE: begin
                    if (q_kind != rgbseq_pkg::CMD_TICK) begin
                        exit_next = (q_kind != rgbseq_pkg::CMD_FADE);
                    end else if (!expire) begin
                        tick_next = tick_inc;
                    end else begin
                        tick_next = '0;
                        if (fr_exit) begin
                            // first exit ramp step
                            phase_next = '0;
                            if (red_reg != 8'd0) begin
                                mode_next = rgbseq_pkg::MODE_EXIT;
                                red_next  = red_reg - 1'b1;
                            end else begin
                                mode_next = rgbseq_pkg::MODE_MANUAL;
                                exit_next = 1'b0;
                            end
                        end else begin
                            red_next   = fr_red;
                            green_next = fr_green;
                            blue_next  = fr_blue;
                            phase_next = fr_phase;
                        end
                    end
                end
                rgbseq_pkg::MODE_EXIT: begin
                    if (q_kind == rgbseq_pkg::CMD_TICK) begin
                        if (!expire) begin
                            tick_next = tick_inc;
                        end else begin
                            tick_next  = '0;
                            phase_next = '0;
                            if (red_reg != 8'd0) begin
                                red_next = red_reg - 1'b1;
                            end else begin
                                mode_next = rgbseq_pkg::MODE_MANUAL;
                                exit_next = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= rgbseq_pkg::MODE_MANUAL;
            phase_reg <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
            tick_reg  <= '0;
            exit_reg  <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            tick_reg  <= tick_next;
            exit_reg  <= exit_next;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (q_pop) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_tdata_reg <= {6'd0, mode_next, blue_next, green_next, red_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == rgbseq_pkg::MODE_MANUAL |-> (phase_reg == '0 && tick_reg == '0 && !exit_reg))
        else $error("manual mode with stale sequencer state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == rgbseq_pkg::MODE_FLASH |-> phase_reg <= rgbseq_pkg::FLASH_BLUE)
        else $error("flash phase out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == rgbseq_pkg::MODE_FADE |-> phase_reg != rgbseq_pkg::FADE_CHECK)
        else $error("fade check phase was stored");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(q_pop))
        else $error("result shown without a popped command");

endmodule

@@ design/rgb_led_command_sequencer.sv @@
// Top level of the RGB LED command sequencer: front end, command queue and
// back end. Depends on rgbseq_pkg, rgbseq_front, rgbseq_queue, rgbseq_back.
`timescale 1ns / 1ps
//
//  Channel   Direction  Contents
//  s_*       in         tdata: cmd_byte; tuser: op (1 = tick, 0 = command byte)
//  m_*       out        tdata: red_duty, green_duty, blue_duty, active_mode
//  cfg_*     in         write enable, register index 0..4, 16-bit write data
//
//  One result per input transaction; one transaction per cycle sustained
//  while results are taken. Input passes through a 2-entry queue into the
//  result register. Unless the result stalls, the back end applies one
//  command per cycle: a compare, a level step and a tick counter update.
//  Reset (aresetn low, synchronous) clears levels, mode and queue and loads
//  the register defaults. A stalled result holds and the queue absorbs inputs.

module rgb_led_command_sequencer #(
    parameter int TICK_COUNT_WIDTH = rgbseq_pkg::TICK_COUNT_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] cmd_byte
    input  logic                                s_tuser,   // [0] op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] red_duty, [15:8] green_duty, [23:16] blue_duty, [25:24] active_mode
    output logic [rgbseq_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [rgbseq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rgbseq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic                  q_push, q_pop, q_full, q_empty;
    rgbseq_pkg::cmd_kind_t push_kind, head_kind;

    rgbseq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_kind   (push_kind)
    );

    rgbseq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_kind (push_kind),
        .pop       (q_pop),
        .head_kind (head_kind),
        .empty     (q_empty),
        .full      (q_full)
    );

    rgbseq_back #(
        .TICK_W (TICK_COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_empty   (q_empty),
        .q_kind    (head_kind),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ verif/rgb_led_command_sequencer_tb.sv @@
// Self-checking testbench for rgb_led_command_sequencer: streams command bytes and
// ticks, predicts the duty levels and mode for every transaction and compares them.
// Depends on rgbseq_pkg and the rgb_led_command_sequencer RTL.
`timescale 1ns / 1ps

module rgb_led_command_sequencer_tb;
    import rgbseq_pkg::*;

    localparam int          CYCLE_LIMIT     = 1_000_000;
    localparam int          RANDOM_ITEMS    = 100;
    localparam int          FADE_ITEM_LIMIT = 400;
    localparam int          HOLDOFF_CYCLES  = 60;
    localparam int          DRAIN_CYCLES    = 4;
    localparam int          MAX_PRINTS      = 50;
    localparam logic [7:0]  CH_RANDOM_MODE  = 8'h73;

    // Predicts levels and mode per transaction and checks the result stream
    class duty_scoreboard;
        logic [7:0]                  red_cap;
        logic [7:0]                  green_cap;
        logic [15:0]                 hold_len;
        logic [9:0]                  step_len;
        logic [15:0]                 pause_len;
        logic [7:0]                  red;
        logic [7:0]                  green;
        logic [7:0]                  blue;
        mode_t                       mode;
        phase_t                      phase;
        logic [TICK_COUNT_WIDTH-1:0] ticks;
        bit                          leave_req;
        logic [OUT_DATA_W-1:0]       duty_queue[$];
        int                          errors;

        function new();
            red_cap   = RST_RED_CAP;
            green_cap = RST_GREEN_CAP;
            hold_len  = RST_FLASH_HOLD;
            step_len  = RST_FADE_STEP;
            pause_len = RST_FADE_PAUSE;
            red       = '0;
            green     = '0;
            blue      = '0;
            errors    = 0;
            to_manual();
        endfunction

        function int pending();
            return duty_queue.size();
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_RED_CAP:    red_cap   = value[7:0];
                CFG_GREEN_CAP:  green_cap = value[7:0];
                CFG_FLASH_HOLD: hold_len  = value[15:0];
                CFG_FADE_STEP:  step_len  = value[9:0];
                CFG_FADE_PAUSE: pause_len = value[15:0];
                default: ;
            endcase
        endfunction

        function void to_manual();
            mode      = MODE_MANUAL;
            phase     = '0;
            leave_req = 1'b0;
            ticks     = '0;
        endfunction

        function void ramp_exit_step();
            mode  = MODE_EXIT;
            phase = '0;
            ticks = '0;
            if (red != 0) begin
                red--;
            end else begin
                to_manual();
            end
        endfunction

        // Walk fade phases from start until one performs a step and waits
        function void fade_advance(phase_t start);
            phase_t p;
            p     = start;
            ticks = '0;
            while (1'b1) begin
                case (p)
                    FADE_RED_UP: begin
                        if (red < red_cap) begin
                            red++;
                            phase = FADE_RED_UP;
                            return;
                        end
                        p = FADE_CHECK;
                    end
                    FADE_RG_CROSS: begin
                        if (green < green_cap) begin
                            if (red != 0) red--;
                            green++;
                            phase = FADE_RG_CROSS;
                            return;
                        end
                        p = FADE_GB_CROSS;
                    end
                    FADE_GB_CROSS: begin
                        if (blue < LEVEL_FULL) begin
                            if (green != 0) green--;
                            blue++;
                            phase = FADE_GB_CROSS;
                            return;
                        end
                        p = FADE_RED_BACK;
                    end
                    FADE_RED_BACK: begin
                        if (red < red_cap) begin
                            red++;
                            phase = FADE_RED_BACK;
                            return;
                        end
                        p = FADE_GRN_BACK;
                    end
                    FADE_GRN_BACK: begin
                        if (green < green_cap) begin
                            green++;
                            phase = FADE_GRN_BACK;
                            return;
                        end
                        p = FADE_GB_DOWN;
                    end
                    FADE_GB_DOWN: begin
                        if (green != 0 || blue != 0) begin
                            if (green != 0) green--;
                            if (blue != 0) blue--;
                            phase = FADE_GB_DOWN;
                            return;
                        end
                        phase = FADE_PAUSE;
                        return;
                    end
                    default: begin
                        // Cycle boundary: leave if asked, else start the cross ramps
                        if (leave_req) begin
                            ramp_exit_step();
                            return;
                        end
                        p = FADE_RG_CROSS;
                    end
                endcase
            end
        endfunction

        function void flash_advance();
            ticks = '0;
            case (phase)
                FLASH_RED: begin
                    red   = '0;
                    green = green_cap;
                    phase = FLASH_GREEN;
                end
                FLASH_GREEN: begin
                    green = '0;
                    blue  = LEVEL_FULL;
                    phase = FLASH_BLUE;
                end
                default: begin
                    blue = '0;
                    if (leave_req) begin
                        red   = '0;
                        green = '0;
                        to_manual();
                    end else begin
                        red   = red_cap;
                        phase = FLASH_RED;
                    end
                end
            endcase
        endfunction

        function void tick_step();
            int unsigned                 wait_len;
            logic [TICK_COUNT_WIDTH-1:0] next_count;
            if (mode == MODE_MANUAL) return;
            if (mode == MODE_FLASH) wait_len = hold_len;
            else if (mode == MODE_FADE && phase == FADE_PAUSE) wait_len = pause_len;
            else wait_len = step_len;
            // A zero wait behaves as one tick
            if (wait_len == 0) wait_len = 1;
            next_count = ticks + 1'b1;
            if (next_count >= wait_len || next_count == '1) begin
                if (mode == MODE_FLASH) flash_advance();
                else if (mode == MODE_FADE) fade_advance(phase == FADE_PAUSE ? FADE_CHECK : phase);
                else ramp_exit_step();
            end else begin
                ticks = next_count;
            end
        endfunction

        function void byte_step(logic [7:0] cmd);
            case (mode)
                MODE_FLASH: leave_req = (cmd != CH_FLASH);
                MODE_FADE:  leave_req = (cmd != CH_FADE);
                MODE_EXIT:  ;
                default: begin
                    case (cmd)
                        CH_RED_DN: if (red != 0) red--;
                        CH_RED_UP: if (red != LEVEL_FULL) red++;
                        CH_GRN_DN: if (green != 0) green--;
                        CH_GRN_UP: if (green != LEVEL_FULL) green++;
                        CH_BLU_DN: if (blue != 0) blue--;
                        CH_BLU_UP: if (blue != LEVEL_FULL) blue++;
                        CH_FLASH: begin
                            mode      = MODE_FLASH;
                            phase     = FLASH_RED;
                            leave_req = 1'b0;
                            ticks     = '0;
                            red       = red_cap;
                        end
                        CH_FADE: begin
                            mode      = MODE_FADE;
                            leave_req = 1'b0;
                            fade_advance(FADE_RED_UP);
                        end
                        default: ;
                    endcase
                end
            endcase
        endfunction

        // Note an accepted input transaction and queue the levels it leaves
        function void accept_command(logic op, logic [7:0] cmd);
            if (op) tick_step();
            else byte_step(cmd);
            duty_queue.push_back({6'b0, mode, blue, green, red});
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            if (errors < MAX_PRINTS) begin
                $display("%0t ns: %s mismatch, got %0d expected %0d", $time, field, got, want);
            end
            errors++;
        endtask

        // Check one accepted result against the oldest prediction
        task compare_duty(logic [OUT_DATA_W-1:0] word);
            logic [OUT_DATA_W-1:0] want;
            if (duty_queue.size() == 0) begin
                report_mismatch("unexpected result", word, 32'd0);
                return;
            end
            want = duty_queue.pop_front();
            if (word[7:0] !== want[7:0]) report_mismatch("red_duty", word[7:0], want[7:0]);
            if (word[15:8] !== want[15:8]) report_mismatch("green_duty", word[15:8], want[15:8]);
            if (word[23:16] !== want[23:16]) begin
                report_mismatch("blue_duty", word[23:16], want[23:16]);
            end
            if (word[25:24] !== want[25:24]) begin
                report_mismatch("active_mode", word[25:24], want[25:24]);
            end
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    duty_scoreboard duty_check;
    bit             calm         = 1'b0;
    bit             holdoff_go   = 1'b0;
    int             holdoff_left = 0;
    int             cycle_count  = 0;
    int             items_sent   = 0;

    rgb_led_command_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rgb_led_command_sequencer_tb NOT OK");
            $finish;
        end
    end

    // Receive side: check results, stall at random or for a requested hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) duty_check.compare_duty(m_tdata);
        if (holdoff_go) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_go   = 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 9);
        end
    end

    function automatic logic [7:0] pick_step_cmd();
        case ($urandom_range(5))
            0:       return CH_RED_DN;
            1:       return CH_RED_UP;
            2:       return CH_GRN_DN;
            3:       return CH_GRN_UP;
            4:       return CH_BLU_DN;
            default: return CH_BLU_UP;
        endcase
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(3))
            0:       return CH_FLASH;
            1:       return CH_FADE;
            2:       return CH_RANDOM_MODE;
            default: return pick_step_cmd();
        endcase
    endfunction

    // Any byte other than the given one, half of them drawn from pick_command
    function automatic logic [7:0] pick_other(logic [7:0] own);
        logic [7:0] b;
        do begin
            b = ($urandom_range(1) != 0) ? pick_command() : 8'($urandom_range(255));
        end while (b == own);
        return b;
    endfunction

    // Offer one transaction, at random idling first, and hold until accepted
    task automatic send_item(input logic op, input logic [7:0] cmd);
        int gap;
        gap = (!calm && $urandom_range(99) < 9) ? 1 : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= cmd;
        do @(posedge aclk); while (!s_tready);
        duty_check.accept_command(op, cmd);
        items_sent++;
    endtask

    // Drop valid and wait for every predicted result
    task automatic wait_for_duties();
        s_tvalid <= 1'b0;
        while (duty_check.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all five registers; upper data bits carry junk the block must drop
    task automatic apply_settings(input logic [7:0] rc, input logic [7:0] gc,
                                  input logic [15:0] hold, input logic [9:0] step_ticks,
                                  input logic [15:0] pause);
        logic [CFG_INDEX_W-1:0] idx [5];
        logic [CFG_DATA_W-1:0]  val [5];
        idx = '{CFG_RED_CAP, CFG_GREEN_CAP, CFG_FLASH_HOLD, CFG_FADE_STEP, CFG_FADE_PAUSE};
        val = '{{8'($urandom_range(255)), rc}, {8'($urandom_range(255)), gc}, hold,
                {6'($urandom_range(63)), step_ticks}, pause};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            duty_check.set_register(idx[i], val[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_manual_burst(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 75) send_item(1'b0, pick_step_cmd());
            else if (r < 88) send_item(1'b0, 8'($urandom_range(255)));
            else send_item(1'b1, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_noise(input int count);
        for (int k = 0; k < count; k++) begin
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    // Enter an auto mode, keep it alive with its own byte, ask to leave at leave_at
    task automatic run_auto(input logic [7:0] own, input int limit, input int leave_at);
        int n;
        send_item(1'b0, own);
        for (n = 1; n < limit && duty_check.mode != MODE_MANUAL; n++) begin
            if (n == leave_at) send_item(1'b0, pick_other(own));
            else if (n < leave_at && $urandom_range(99) < 15) send_item(1'b0, own);
            else if (duty_check.mode == MODE_EXIT && $urandom_range(99) < 20) begin
                send_item(1'b0, 8'($urandom_range(255)));
            end else begin
                send_item(1'b1, 8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        logic [8:0] opening [7];
        logic [8:0] flash_run [11];
        int         base;
        int         n;
        int         nseq;
        bit         asked;

        duty_check = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Small caps, zero hold and step waits (act as one tick), short fade pause
        apply_settings(8'd3, 8'd0, 16'd0, 10'd0, 16'd5);

        // Tick in manual, steps down at zero, ignored bytes, byte extremes
        opening = '{{1'b1, 8'hFF}, {1'b0, CH_RED_DN}, {1'b0, CH_GRN_DN}, {1'b0, CH_BLU_DN},
                    {1'b0, CH_RANDOM_MODE}, {1'b0, 8'h00}, {1'b0, 8'hFF}};
        foreach (opening[i]) send_item(opening[i][8], opening[i][7:0]);

        // Ramp blue past full scale
        for (int k = 0; k < 257; k++) begin
            send_item(1'b0, CH_BLU_UP);
        end

        // Fade cycle from full blue through the pause, leave, then the exit ramp
        send_item(1'b0, CH_FADE);
        n     = 0;
        asked = 1'b0;
        while (duty_check.mode != MODE_MANUAL && n < FADE_ITEM_LIMIT) begin
            if (!asked && duty_check.mode == MODE_FADE && duty_check.phase == FADE_PAUSE) begin
                send_item(1'b0, pick_other(CH_FADE));
                asked = 1'b1;
            end else if (duty_check.mode == MODE_EXIT && n[0]) begin
                send_item(1'b0, CH_RED_DN);
            end else begin
                send_item(1'b1, 8'($urandom_range(255)));
            end
            n++;
        end

        // Flash with leave request set and cancelled, leave, then enter fade
        flash_run = '{{1'b0, CH_FLASH}, {1'b0, 8'h7A}, {1'b0, CH_FLASH}, {1'b1, 8'h00},
                      {1'b1, 8'h5A}, {1'b0, 8'h71}, {1'b1, 8'hA5}, {1'b0, CH_FADE},
                      {1'b1, 8'h3C}, {1'b0, 8'h78}, {1'b0, CH_FADE}};
        foreach (flash_run[i]) send_item(flash_run[i][8], flash_run[i][7:0]);

        // Random phases, each with its own register settings
        base = items_sent;
        for (int ph = 0; ph < 6 || items_sent - base < RANDOM_ITEMS; ph++) begin
            wait_for_duties();
            calm = (ph % 6 == 1);
            case (ph % 6)
                2: apply_settings(8'd255, 8'd255, 16'd1, 10'd1, 16'd1);
                3: apply_settings(8'($urandom_range(4)), 8'($urandom_range(4)),
                                  16'($urandom_range(1, 4)), 10'd1, 16'd3);
                4: apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  16'hFFFF, 10'h3FF, 16'hFFFF);
                5: apply_settings(8'd0, 8'd0, 16'd0, 10'd0, 16'd0);
                default: apply_settings(8'($urandom_range(12)), 8'($urandom_range(12)),
                                        16'($urandom_range(4)), 10'($urandom_range(2)),
                                        16'($urandom_range(4)));
            endcase
            // Run a stretch with no idling on either side
            if (ph % 6 == 1) run_noise(24);
            // Stall the result side while items keep coming
            if (ph % 6 == 2) begin
                holdoff_go = 1'b1;
                run_noise(12);
            end
            nseq = $urandom_range(1, 2);
            for (int s = 0; s < nseq; s++) begin
                case ($urandom_range(5))
                    0, 1:    run_manual_burst($urandom_range(1, 10));
                    2:       run_auto(CH_FLASH, $urandom_range(6, 30), $urandom_range(1, 20));
                    3:       run_auto(CH_FADE, $urandom_range(6, 40), $urandom_range(1, 30));
                    default: run_noise($urandom_range(1, 8));
                endcase
            end
        end

        calm = 1'b0;
        wait_for_duties();
        repeat (8) @(posedge aclk);
        if (duty_check.errors == 0 && duty_check.pending() == 0) begin
            $display("rgb_led_command_sequencer_tb OK");
        end else begin
            $display("rgb_led_command_sequencer_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/rgbseq_pkg.sv
design/rgbseq_front.sv
design/rgbseq_queue.sv
design/rgbseq_back.sv
design/rgb_led_command_sequencer.sv
verif/rgb_led_command_sequencer_tb.sv
